// ----- hdl/positional_list_insert_remove_macros.svh -----
// Assertion macros for the positional list block
`ifndef POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication
`define PLIST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list check failed");

// next-cycle implication
`define PLIST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list check failed");

`endif

// ----- hdl/plist_pkg.sv -----
// Shared constants and types for the positional list block
package plist_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int REQ_W        = 2;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int INDEX_W      = 5;
    localparam int ITEM_COUNT_W = 6;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam int VALUE_LSB       = 0;
    localparam int POS_LSB         = 32;
    localparam int ENTRY_VALUE_LSB = 0;
    localparam int ENTRY_INDEX_LSB = 32;
    localparam int ITEM_COUNT_LSB  = 37;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic down;
        logic use_step;
    } step_ctl_t;

endpackage

// ----- hdl/positional_list_insert_remove.sv -----
// Positional list top level: sequencer, output register, storage and index unit.
// Insert: entries at pos and above move up, one entry per cycle; then the value goes in at pos.
// Remove: entries above pos move down one place, then the count drops.
// Dump: entries go out from index 0 up, one entry per cycle while m_tready holds.
// Bad, full, empty: answered from ST_RESP; one request at a time, s_tready low while busy.
// Reset: rst_n asynchronous active low, count cleared; entry storage is not cleared.
module positional_list_insert_remove #(
    parameter int CAPACITY = plist_pkg::DEF_CAPACITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plist_pkg::S_TDATA_W-1:0] s_tdata,  // value, position, pad
    input  logic [plist_pkg::REQ_W-1:0]     s_tuser,  // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plist_pkg::M_TDATA_W-1:0] m_tdata,  // entry_value, entry_index, item_count, pad
    output logic [plist_pkg::STATUS_W-1:0]  m_tuser,  // status
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_DUMP = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   ptr_reg, ptr_next;
    logic [CNT_W-1:0]                   pos_reg, pos_next;
    logic [plist_pkg::VALUE_W-1:0]      val_reg, val_next;
    logic [IDX_W-1:0]                   wr_addr_reg, wr_addr_next;
    logic                               wr_pend_reg, wr_pend_next;
    logic                               rd_pend_reg, rd_pend_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   oidx_reg, oidx_next;
    logic                               olast_reg, olast_next;
    logic [plist_pkg::STATUS_W-1:0]     status_reg, status_next;

    logic                               out_valid_reg, out_valid_next;
    logic [plist_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [plist_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [plist_pkg::INDEX_W-1:0]      out_index_reg, out_index_next;
    logic [plist_pkg::ITEM_COUNT_W-1:0] out_count_reg, out_count_next;
    logic                               out_last_reg, out_last_next;

    logic                               mem_wr_en;
    logic [IDX_W-1:0]                   mem_wr_addr;
    logic [plist_pkg::VALUE_W-1:0]      mem_wr_data;
    logic                               mem_rd_en;
    logic [IDX_W-1:0]                   mem_rd_addr;
    logic [plist_pkg::VALUE_W-1:0]      mem_rd_data;

    plist_pkg::step_ctl_t               step_ctl;
    logic [CNT_W-1:0]                   step_limit;
    logic [CNT_W-1:0]                   step_val;
    logic                               step_lt;

    logic [plist_pkg::REQ_W-1:0]        in_req;
    logic [plist_pkg::VALUE_W-1:0]      in_value;
    logic [plist_pkg::POS_W-1:0]        in_pos;
    logic [CMP_W-1:0]                   pos_c;
    logic [CMP_W-1:0]                   cnt_c;
    logic                               full;
    logic                               out_free;

    plist_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    plist_step #(
        .W (CNT_W)
    ) u_step (
        .ptr   (ptr_reg),
        .limit (step_limit),
        .ctl   (step_ctl),
        .step  (step_val),
        .lt    (step_lt)
    );

    assign in_req   = s_tuser;
    assign in_value = s_tdata[plist_pkg::VALUE_LSB +: plist_pkg::VALUE_W];
    assign in_pos   = s_tdata[plist_pkg::POS_LSB +: plist_pkg::POS_W];
    assign pos_c    = CMP_W'(in_pos);
    assign cnt_c    = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_count_reg, out_index_reg, out_value_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        wr_addr_next    = wr_addr_reg;
        wr_pend_next    = wr_pend_reg;
        rd_pend_next    = rd_pend_reg;
        done_next       = done_reg;
        oidx_next       = oidx_reg;
        olast_next      = olast_reg;
        status_next     = status_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        mem_wr_en       = 1'b0;
        mem_wr_addr     = wr_addr_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;

        step_ctl.down     = 1'b0;
        step_ctl.use_step = 1'b1;
        step_limit        = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next = plist_pkg::ST_BAD_POS;
                    state_next  = ST_RESP;
                    unique case (in_req)
                        plist_pkg::REQ_INSERT:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                status_next = plist_pkg::ST_BAD_POS;
                            end
                            else if (full)
                            begin
                                status_next = plist_pkg::ST_FULL;
                            end
                            else
                            begin
                                ptr_next     = count_reg;
                                pos_next     = CNT_W'(in_pos);
                                val_next     = in_value;
                                wr_pend_next = 1'b0;
                                state_next   = ST_INS;
                            end
                        end
                        plist_pkg::REQ_REMOVE:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                ptr_next     = CNT_W'(in_pos);
                                wr_pend_next = 1'b0;
                                state_next   = ST_REM;
                            end
                        end
                        plist_pkg::REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = plist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next     = '0;
                                done_next    = 1'b0;
                                rd_pend_next = 1'b0;
                                state_next   = ST_DUMP;
                            end
                        end
                        plist_pkg::REQ_UNUSED:
                        begin
                            status_next = plist_pkg::ST_BAD_POS;
                        end
                        default:
                        begin
                            status_next = plist_pkg::ST_BAD_POS;
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                // move entries up from the top down to pos, one per cycle
                step_ctl.down     = 1'b1;
                step_ctl.use_step = 1'b0;
                step_limit        = pos_reg;
                if (step_lt)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = step_val[IDX_W-1:0];
                    mem_wr_en    = wr_pend_reg;
                    wr_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = step_val;
                    wr_pend_next = 1'b1;
                end
                else if (wr_pend_reg)
                begin
                    mem_wr_en    = 1'b1;
                    wr_pend_next = 1'b0;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg[IDX_W-1:0];
                    mem_wr_data = val_reg;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = plist_pkg::ST_OK;
                    state_next  = ST_RESP;
                end
            end

            ST_REM:
            begin
                // move entries down from pos+1 to the top
                if (step_lt)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = step_val[IDX_W-1:0];
                    mem_wr_en    = wr_pend_reg;
                    wr_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = step_val;
                    wr_pend_next = 1'b1;
                end
                else if (wr_pend_reg)
                begin
                    mem_wr_en    = 1'b1;
                    wr_pend_next = 1'b0;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = plist_pkg::ST_OK;
                    state_next  = ST_RESP;
                end
            end

            ST_DUMP:
            begin
                if (rd_pend_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = plist_pkg::ST_OK;
                    out_value_next  = mem_rd_data;
                    out_index_next  = plist_pkg::INDEX_W'(oidx_reg);
                    out_count_next  = plist_pkg::ITEM_COUNT_W'(count_reg);
                    out_last_next   = olast_reg;
                    rd_pend_next    = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (!done_reg && (!rd_pend_reg || out_free))
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = ptr_reg[IDX_W-1:0];
                    oidx_next    = ptr_reg;
                    olast_next   = !step_lt;
                    done_next    = !step_lt;
                    ptr_next     = step_val;
                    rd_pend_next = 1'b1;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = '0;
                    out_index_next  = '0;
                    out_count_next  = plist_pkg::ITEM_COUNT_W'(count_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            rd_pend_reg   <= rd_pend_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        wr_addr_reg    <= wr_addr_next;
        oidx_reg       <= oidx_next;
        olast_reg      <= olast_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- hdl/plist_mem.sv -----
// Entry storage: one write port, one registered read port
module plist_mem #(
    parameter int DEPTH  = plist_pkg::DEF_CAPACITY,
    parameter int ADDR_W = $clog2(plist_pkg::DEF_CAPACITY)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [plist_pkg::VALUE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [plist_pkg::VALUE_W-1:0] rd_data
);

    logic [plist_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/plist_step.sv -----
// Shared index unit: pointer step and one of two selectable compares
module plist_step #(
    parameter int W = $clog2(plist_pkg::DEF_CAPACITY + 1)
) (
    input  logic                 [W-1:0] ptr,
    input  logic                 [W-1:0] limit,
    input  plist_pkg::step_ctl_t         ctl,
    output logic                 [W-1:0] step,
    output logic                         lt
);

    always_comb
    begin
        step = ctl.down ? (ptr - W'(1)) : (ptr + W'(1));
        lt   = ctl.use_step ? (step < limit) : (limit < ptr);
    end

endmodule

// ----- hdl/plist_checker.sv -----
// Port-level checks for the positional list block, bound to the top level
`include "positional_list_insert_remove_macros.svh"

module plist_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [plist_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [plist_pkg::REQ_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [plist_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [plist_pkg::STATUS_W-1:0]  m_tuser,
    input logic                            m_tlast
);

    logic [plist_pkg::ITEM_COUNT_W-1:0] out_count;

    assign out_count = m_tdata[plist_pkg::ITEM_COUNT_LSB +: plist_pkg::ITEM_COUNT_W];

    `PLIST_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    `PLIST_ASSERT_NOW(a_partial_is_ok, m_tvalid && !m_tlast, m_tuser == plist_pkg::ST_OK)

    `PLIST_ASSERT_NOW(a_empty_count_zero, m_tvalid && (m_tuser == plist_pkg::ST_EMPTY), out_count == '0)

    `PLIST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind positional_list_insert_remove plist_checker u_plist_checker (.*);
